### design/swr_pkg.sv
// Shared constants, types and helpers for the stream word replace block.
package swr_pkg;

   // Config register widths and fixed byte counts
   localparam int WORD_BYTES   = 8;
   localparam int WORD_W       = 64;
   localparam int LEN_W        = 4;
   localparam int BYTE_IDX_W   = 3;
   localparam int CSR_IDX_W    = 2;
   localparam int DEF_MAX_WORD = 8;

   // Config register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MATCH_WORD     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MATCH_LENGTH   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REPLACE_WORD   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_REPLACE_LENGTH = 2'd3;

   // Word delimiters
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_PERIOD  = 8'h2E;
   localparam logic [7:0] CHAR_COMMA   = 8'h2C;
   localparam logic [7:0] CHAR_COLON   = 8'h3A;

   // Configuration as seen by the sequencer
   typedef struct packed {
      logic [WORD_W-1:0] match_word;
      logic [LEN_W-1:0]  match_length;
      logic [WORD_W-1:0] replace_word;
      logic [LEN_W-1:0]  replace_length;
   } swr_cfg_type;

   function automatic logic is_delim(input logic [7:0] c);
      return (c == CHAR_NEWLINE) || (c == CHAR_SPACE) || (c == CHAR_PERIOD) ||
             (c == CHAR_COMMA) || (c == CHAR_COLON);
   endfunction

   function automatic logic [7:0] byte_of(input logic [WORD_W-1:0] packed_word,
                                          input logic [BYTE_IDX_W-1:0] idx);
      return packed_word[idx*8 +: 8];
   endfunction

endpackage

### design/swr_csr.sv
// Configuration register file for the stream word replace block.
module swr_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [swr_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [swr_pkg::WORD_W-1:0]         csr_data,
   output swr_pkg::swr_cfg_type               cfg
);

   swr_pkg::swr_cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // Register decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            swr_pkg::CSR_MATCH_WORD:     cfg_in.match_word     = csr_data;
            swr_pkg::CSR_MATCH_LENGTH:   cfg_in.match_length   =
                                            csr_data[swr_pkg::LEN_W-1:0];
            swr_pkg::CSR_REPLACE_WORD:   cfg_in.replace_word   = csr_data;
            swr_pkg::CSR_REPLACE_LENGTH: cfg_in.replace_length =
                                            csr_data[swr_pkg::LEN_W-1:0];
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### design/swr_word_buf.sv
// Word buffer: holds the bytes of the word being collected.
module swr_word_buf #(
   parameter int MAX_WORD = swr_pkg::DEF_MAX_WORD,
   parameter int ADDR_W   = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [7:0]        wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]        rd_data
);

   logic [7:0] store_ff [MAX_WORD];

   // Byte write, no reset: only written entries are ever read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   assign rd_data = store_ff[rd_addr];

endmodule

### design/swr_seq.sv
// Sequencer: collects words, compares byte by byte and emits output bytes.
module swr_seq #(
   parameter int MAX_WORD = swr_pkg::DEF_MAX_WORD
) (
   input  logic                 clock,
   input  logic                 reset,
   input  swr_pkg::swr_cfg_type cfg,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_in_char,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [7:0]           rsp_out_char,
   output logic                 rsp_last_of_run
);

   localparam int ADDR_W = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;
   localparam int CNT_W  = $clog2(MAX_WORD + 1);
   localparam int LEN_W  = swr_pkg::LEN_W;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_CMP  = 2'd1;
   localparam logic [1:0] S_EMIT = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pass_ff, pass_in;
   logic [7:0]       char_ff, char_in;
   logic [LEN_W-1:0] idx_ff, idx_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic             match_ff, match_in;
   logic             src_rep_ff, src_rep_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       rsp_char_ff, rsp_char_in;
   logic             rsp_last_ff, rsp_last_in;

   logic             accept;
   logic             delim;
   logic             buf_wr_en;
   logic [7:0]       buf_rd_data;
   logic [LEN_W-1:0] count_ext;
   logic [LEN_W-1:0] rep_len_sat;
   logic             out_free;

   swr_word_buf #(
      .MAX_WORD (MAX_WORD),
      .ADDR_W   (ADDR_W)
   ) u_word_buf (
      .clock   (clock),
      .wr_en   (buf_wr_en),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (req_in_char),
      .rd_addr (idx_ff[ADDR_W-1:0]),
      .rd_data (buf_rd_data)
   );

   assign req_ready       = (state_ff == S_IDLE);
   assign accept          = req_valid && req_ready;
   assign delim           = swr_pkg::is_delim(req_in_char);
   assign count_ext       = LEN_W'(count_ff);
   assign rep_len_sat     = (cfg.replace_length > LEN_W'(swr_pkg::WORD_BYTES)) ?
                            LEN_W'(swr_pkg::WORD_BYTES) : cfg.replace_length;
   assign out_free        = !rsp_valid_ff || rsp_ready;
   assign buf_wr_en       = accept && !delim && !pass_ff &&
                            (count_ff < CNT_W'(MAX_WORD));
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_char    = rsp_char_ff;
   assign rsp_last_of_run = rsp_last_ff;

   // Next state
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      pass_in      = pass_ff;
      char_in      = char_ff;
      idx_in       = idx_ff;
      len_in       = len_ff;
      match_in     = match_ff;
      src_rep_in   = src_rep_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               char_in    = req_in_char;
               idx_in     = '0;
               src_rep_in = 1'b0;
               if (!delim) begin
                  if (pass_ff) begin
                     // echo a byte of an overflowed word
                     len_in   = '0;
                     state_in = S_EMIT;
                  end else if (count_ff < CNT_W'(MAX_WORD)) begin
                     count_in = count_ff + CNT_W'(1);
                  end else begin
                     // overflow: flush buffer plus this byte
                     len_in   = count_ext;
                     count_in = '0;
                     pass_in  = 1'b1;
                     state_in = S_EMIT;
                  end
               end else if (pass_ff) begin
                  // delimiter ends an overflowed word
                  pass_in  = 1'b0;
                  len_in   = '0;
                  state_in = S_EMIT;
               end else begin
                  match_in = (cfg.match_length == count_ext);
                  state_in = S_CMP;
               end
            end
         end

         S_CMP: begin
            // one byte compared per cycle
            if (!match_ff || idx_ff == count_ext) begin
               src_rep_in = match_ff;
               len_in     = match_ff ? rep_len_sat : count_ext;
               idx_in     = '0;
               count_in   = '0;
               state_in   = S_EMIT;
            end else begin
               match_in = buf_rd_data ==
                          swr_pkg::byte_of(cfg.match_word,
                                           idx_ff[swr_pkg::BYTE_IDX_W-1:0]);
               idx_in   = idx_ff + LEN_W'(1);
            end
         end

         S_EMIT: begin
            // one byte into the output register whenever it is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (idx_ff < len_ff) begin
                  rsp_char_in = src_rep_ff ?
                                swr_pkg::byte_of(cfg.replace_word,
                                                 idx_ff[swr_pkg::BYTE_IDX_W-1:0]) :
                                buf_rd_data;
                  rsp_last_in = 1'b0;
                  idx_in      = idx_ff + LEN_W'(1);
               end else begin
                  rsp_char_in = char_ff;
                  rsp_last_in = 1'b1;
                  state_in    = S_IDLE;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         pass_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pass_ff      <= pass_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and working registers
   always_ff @(posedge clock) begin
      char_ff     <= char_in;
      idx_ff      <= idx_in;
      len_ff      <= len_in;
      match_ff    <= match_in;
      src_rep_ff  <= src_rep_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

endmodule

### design/stream_word_replace.sv
// Whole-word find and replace: each word byte is accepted while idle and buffered.
// A delimiter with n buffered bytes starts byte compares that stop at a mismatch,
// then one byte per cycle unless stalled (n or replace bytes, then the delimiter).
// An overflow or pass-through byte skips the compare and starts output at once.
// The request side is held off until the last output byte is registered.
// Synchronous reset clears config registers, word count and handshake state.
module stream_word_replace #(
   parameter int MAX_WORD = swr_pkg::DEF_MAX_WORD
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [swr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [swr_pkg::WORD_W-1:0]    csr_data,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [7:0]                    req_in_char,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [7:0]                    rsp_out_char,
   output logic                          rsp_last_of_run
);

   swr_pkg::swr_cfg_type cfg;

   swr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   swr_seq #(
      .MAX_WORD (MAX_WORD)
   ) u_seq (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_in_char     (req_in_char),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_char    (rsp_out_char),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule
